### hdl/pst_pkg.sv
package pst_pkg;

  typedef enum logic [2:0] {
    CMD_WR_MAP    = 3'd0,
    CMD_WR_SIZE   = 3'd1,
    CMD_RD_MAP    = 3'd2,
    CMD_RD_SIZE   = 3'd3,
    CMD_CHECK     = 3'd4,
    CMD_TRANSLATE = 3'd5,
    CMD_AUTOPART  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_BAD_DEVICE = 3'd2,
    ST_BAD_SECTOR = 3'd3,
    ST_BAD_ENTRY  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    CFG_READY         = 3'd0,
    CFG_IS_MASTER     = 3'd1,
    CFG_SECOND_DRIVE  = 3'd2,
    CFG_BASE_ID       = 3'd3,
    CFG_MASTER_ID     = 3'd4,
    CFG_SLAVE_ID      = 3'd5,
    CFG_OPTIONAL_ID   = 3'd6,
    CFG_DRIVE_SECTORS = 3'd7
  } cfg_idx_e;

  localparam logic [7:0]  BASE_ID_RST   = 8'd49;
  localparam logic [7:0]  MASTER_ID_RST = 8'd112;
  localparam logic [7:0]  SLAVE_ID_RST  = 8'd113;
  localparam logic [7:0]  OPT_ID_RST    = 8'd63;
  localparam logic [15:0] FULL_PART     = 16'hFFFF;
  localparam logic [15:0] SHORT_LAST    = 16'd3;
  localparam logic [8:0]  SHORT_LEN     = 9'd128;

  typedef struct packed {
    logic        ready;
    logic        is_master;
    logic        second_drive;
    logic [7:0]  base_id;
    logic [7:0]  master_id;
    logic [7:0]  slave_id;
    logic [7:0]  opt_id;
    logic [31:0] drive_sectors;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic eval;
    logic walk_step;
    logic auto_step;
    logic out_load;
  } dp_ctl_t;

  typedef struct packed {
    logic early_done;
    logic is_auto;
    logic walk_done;
    logic auto_done;
  } dp_stat_t;

endpackage

### hdl/partitioned_sector_translator_core.sv
// Drive-slot to partition translator. One request is taken at a time and answered with
// one result; the next request is taken while that result still waits in the output
// register. Map and size writes, map reads, refusals and checks on the controller id are
// answered from the eval state. Size reads and disk checks read one size entry in the
// walk state. A translate into partition p walks the size memory from entry 0 up to p
// through its single read port, one entry per cycle. Auto-partition writes the size
// memory one entry per cycle from entry 0, at most PARTITIONS entries in all. The size
// table comes out of reset as all zero through per-entry valid bits, so no clearing
// pass is needed. Configuration writes are always taken and belong between requests.
module partitioned_sector_translator_core #(
  parameter int DISK_SLOTS   = 15,
  parameter int PARTITIONS   = 48,
  parameter int SECTOR_BYTES = 256,
  parameter int NO_DISK_MARK = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [7:0]  device_id_i,
  input  logic        extra_command_i,
  input  logic [15:0] sector_number_i,
  input  logic [5:0]  entry_index_i,
  input  logic [15:0] entry_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        accepted_o,
  output logic [2:0]  status_o,
  output logic [21:0] sector_address_o,
  output logic [8:0]  sector_length_o,
  output logic [15:0] read_value_o
);

  pst_pkg::cfg_t     cfg_q;
  pst_pkg::dp_ctl_t  ctl;
  pst_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ready         <= 1'b0;
      cfg_q.is_master     <= 1'b0;
      cfg_q.second_drive  <= 1'b0;
      cfg_q.base_id       <= pst_pkg::BASE_ID_RST;
      cfg_q.master_id     <= pst_pkg::MASTER_ID_RST;
      cfg_q.slave_id      <= pst_pkg::SLAVE_ID_RST;
      cfg_q.opt_id        <= pst_pkg::OPT_ID_RST;
      cfg_q.drive_sectors <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        pst_pkg::CFG_READY:         cfg_q.ready         <= cfg_data_i[0];
        pst_pkg::CFG_IS_MASTER:     cfg_q.is_master     <= cfg_data_i[0];
        pst_pkg::CFG_SECOND_DRIVE:  cfg_q.second_drive  <= cfg_data_i[0];
        pst_pkg::CFG_BASE_ID:       cfg_q.base_id       <= cfg_data_i[7:0];
        pst_pkg::CFG_MASTER_ID:     cfg_q.master_id     <= cfg_data_i[7:0];
        pst_pkg::CFG_SLAVE_ID:      cfg_q.slave_id      <= cfg_data_i[7:0];
        pst_pkg::CFG_OPTIONAL_ID:   cfg_q.opt_id        <= cfg_data_i[7:0];
        pst_pkg::CFG_DRIVE_SECTORS: cfg_q.drive_sectors <= cfg_data_i;
        default: cfg_q.ready <= cfg_q.ready;
      endcase
    end
  end

  pst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  pst_dp #(
    .DISK_SLOTS   (DISK_SLOTS),
    .PARTITIONS   (PARTITIONS),
    .SECTOR_BYTES (SECTOR_BYTES),
    .NO_DISK_MARK (NO_DISK_MARK)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .stat_o           (stat),
    .cfg_i            (cfg_q),
    .cmd_i            (cmd_i),
    .device_id_i      (device_id_i),
    .extra_command_i  (extra_command_i),
    .sector_number_i  (sector_number_i),
    .entry_index_i    (entry_index_i),
    .entry_value_i    (entry_value_i),
    .accepted_o       (accepted_o),
    .status_o         (status_o),
    .sector_address_o (sector_address_o),
    .sector_length_o  (sector_length_o),
    .read_value_o     (read_value_o)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken while another is in flight");

  a_accept_matches_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (accepted_o == (status_o == pst_pkg::ST_OK)))
    else $error("accepted flag disagrees with status");

  a_fail_clears_sector: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != pst_pkg::ST_OK) |->
      (sector_length_o == 9'd0) && (sector_address_o == 22'd0) && (read_value_o == 16'd0))
    else $error("failed request carries sector data");

endmodule

### hdl/pst_ctrl.sv
module pst_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  pst_pkg::dp_stat_t  stat_i,
  output pst_pkg::dp_ctl_t   ctl_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EVAL = 5'b00010,
    S_WALK = 5'b00100,
    S_AUTO = 5'b01000,
    S_DONE = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_load;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    ctl_o           = '0;
    ctl_o.load      = (state_q == S_IDLE) && in_valid_i;
    ctl_o.eval      = (state_q == S_EVAL);
    ctl_o.walk_step = (state_q == S_WALK);
    ctl_o.auto_step = (state_q == S_AUTO);
    ctl_o.out_load  = out_load;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.early_done)   state_d = S_DONE;
        else if (stat_i.is_auto) state_d = S_AUTO;
        else                     state_d = S_WALK;
      end
      S_WALK: begin
        if (stat_i.walk_done) state_d = S_DONE;
      end
      S_AUTO: begin
        if (stat_i.auto_done) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load)         out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### hdl/pst_dp.sv
module pst_dp #(
  parameter int DISK_SLOTS   = 15,
  parameter int PARTITIONS   = 48,
  parameter int SECTOR_BYTES = 256,
  parameter int NO_DISK_MARK = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pst_pkg::dp_ctl_t   ctl_i,
  output pst_pkg::dp_stat_t  stat_o,
  input  pst_pkg::cfg_t      cfg_i,
  input  logic [2:0]         cmd_i,
  input  logic [7:0]         device_id_i,
  input  logic               extra_command_i,
  input  logic [15:0]        sector_number_i,
  input  logic [5:0]         entry_index_i,
  input  logic [15:0]        entry_value_i,
  output logic               accepted_o,
  output logic [2:0]         status_o,
  output logic [21:0]        sector_address_o,
  output logic [8:0]         sector_length_o,
  output logic [15:0]        read_value_o
);

  localparam int SLOT_AW = (DISK_SLOTS > 1) ? $clog2(DISK_SLOTS) : 1;
  localparam int PART_AW = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
  localparam int CNT_W   = $clog2(PARTITIONS + 1);

  // request registers
  logic [2:0]  cmd_q;
  logic [7:0]  did_q;
  logic        extra_q;
  logic [15:0] sn_q;
  logic [5:0]  idx_q;
  logic [15:0] val_q;

  logic [7:0]  slot_map_q [DISK_SLOTS];

  logic [15:0]           size_mem [PARTITIONS];
  logic [PARTITIONS-1:0] size_vld_q;
  logic [15:0]           rdata_q;
  logic                  rvbit_q;
  logic [15:0]           rsize;

  logic [CNT_W-1:0]   issue_q;
  logic               rd_vld_q;
  logic [PART_AW-1:0] rd_idx_q;
  logic [PART_AW-1:0] target_q;
  logic [21:0]        acc_q;
  logic [21:0]        sec_q;

  pst_pkg::status_e res_status_q, out_status_q;
  logic [21:0]      res_addr_q, out_addr_q;
  logic [8:0]       res_len_q, out_len_q;
  logic [15:0]      res_rd_q, out_rd_q;

  // eval decode
  logic [7:0]         did_off;
  logic               did_in_range;
  logic [7:0]         map_sel;
  logic [7:0]         map_val;
  logic [7:0]         own_id;
  logic               disk_ok;
  logic [PART_AW-1:0] part_sel;
  logic               idx_map_ok;
  logic               idx_part_ok;
  logic               val_ok;
  logic               needs_ready;

  pst_pkg::status_e   ev_status;
  logic [15:0]        ev_rd;
  logic               ev_early;
  logic               ev_auto;
  logic [PART_AW-1:0] ev_target;
  logic [PART_AW-1:0] ev_start;
  logic               ev_map_we;
  logic               ev_size_we;

  // walk and autopart
  logic               issue_go;
  logic               rd_en;
  logic               walk_done;
  pst_pkg::status_e   wk_status;
  logic [21:0]        wk_addr;
  logic [8:0]         wk_len;
  logic [15:0]        wk_rd;
  logic [32:0]        rem;
  logic               full;
  logic [15:0]        auto_val;
  logic               auto_done;
  logic               mem_we;
  logic [PART_AW-1:0] mem_waddr;
  logic [15:0]        mem_wdata;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      cmd_q   <= cmd_i;
      did_q   <= device_id_i;
      extra_q <= extra_command_i;
      sn_q    <= sector_number_i;
      idx_q   <= entry_index_i;
      val_q   <= entry_value_i;
    end
  end

  assign did_off      = did_q - cfg_i.base_id;
  assign did_in_range = (did_q >= cfg_i.base_id) && (did_off < 8'(DISK_SLOTS));
  assign map_sel      = ((cmd_q == pst_pkg::CMD_WR_MAP) || (cmd_q == pst_pkg::CMD_RD_MAP)) ?
                        {2'b00, idx_q} : did_off;
  assign map_val      = (map_sel < 8'(DISK_SLOTS)) ? slot_map_q[map_sel[SLOT_AW-1:0]] : 8'd0;
  assign own_id       = cfg_i.is_master ? cfg_i.master_id : cfg_i.slave_id;
  assign disk_ok      = did_in_range
                        && !(!cfg_i.second_drive && (did_q == cfg_i.opt_id))
                        && (map_val != 8'(NO_DISK_MARK))
                        && (map_val < 8'(PARTITIONS));
  assign part_sel     = map_val[PART_AW-1:0];
  assign idx_map_ok   = ({1'b0, idx_q} < 7'(DISK_SLOTS));
  assign idx_part_ok  = ({1'b0, idx_q} < 7'(PARTITIONS));
  assign val_ok       = (val_q < 16'(PARTITIONS)) || (val_q == 16'(NO_DISK_MARK));

  always_comb begin
    case (cmd_q) inside
      pst_pkg::CMD_WR_MAP, pst_pkg::CMD_WR_SIZE, pst_pkg::CMD_RD_MAP,
      pst_pkg::CMD_RD_SIZE, pst_pkg::CMD_TRANSLATE: needs_ready = 1'b1;
      default: needs_ready = 1'b0;
    endcase
  end

  always_comb begin
    ev_status  = pst_pkg::ST_OK;
    ev_rd      = '0;
    ev_early   = 1'b1;
    ev_auto    = 1'b0;
    ev_target  = part_sel;
    ev_start   = '0;
    ev_map_we  = 1'b0;
    ev_size_we = 1'b0;
    if (needs_ready && !cfg_i.ready) begin
      ev_status = pst_pkg::ST_NOT_READY;
    end else begin
      unique case (cmd_q)
        pst_pkg::CMD_WR_MAP: begin
          if (!idx_map_ok || !val_ok) ev_status = pst_pkg::ST_BAD_ENTRY;
          else                        ev_map_we = 1'b1;
        end
        pst_pkg::CMD_WR_SIZE: begin
          if (!idx_part_ok) ev_status  = pst_pkg::ST_BAD_ENTRY;
          else              ev_size_we = 1'b1;
        end
        pst_pkg::CMD_RD_MAP: begin
          if (!idx_map_ok) ev_status = pst_pkg::ST_BAD_ENTRY;
          else             ev_rd     = {8'd0, map_val};
        end
        pst_pkg::CMD_RD_SIZE: begin
          if (!idx_part_ok) begin
            ev_status = pst_pkg::ST_BAD_ENTRY;
          end else begin
            ev_early  = 1'b0;
            ev_target = idx_q[PART_AW-1:0];
            ev_start  = idx_q[PART_AW-1:0];
          end
        end
        pst_pkg::CMD_CHECK: begin
          if (did_q == own_id) begin
            if (!extra_q) ev_status = pst_pkg::ST_BAD_DEVICE;
          end else if (!disk_ok) begin
            ev_status = pst_pkg::ST_BAD_DEVICE;
          end else begin
            ev_early = 1'b0;
            ev_start = part_sel;
          end
        end
        pst_pkg::CMD_TRANSLATE: begin
          if (!disk_ok) ev_status = pst_pkg::ST_BAD_DEVICE;
          else          ev_early  = 1'b0;
        end
        pst_pkg::CMD_AUTOPART: begin
          ev_early = 1'b0;
          ev_auto  = 1'b1;
        end
        default: ev_status = pst_pkg::ST_BAD_ENTRY;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DISK_SLOTS; i++) slot_map_q[i] <= 8'(i);
    end else if (ctl_i.eval && ev_map_we) begin
      slot_map_q[idx_q[SLOT_AW-1:0]] <= val_q[7:0];
    end
  end

  // size table: walk reads one entry per cycle
  assign issue_go  = (issue_q <= CNT_W'(target_q));
  assign rd_en     = ctl_i.walk_step && issue_go;
  assign rsize     = rvbit_q ? rdata_q : 16'd0;
  assign walk_done = rd_vld_q && (rd_idx_q == target_q);

  always_comb begin
    wk_status = pst_pkg::ST_OK;
    wk_addr   = '0;
    wk_len    = '0;
    wk_rd     = '0;
    unique case (cmd_q)
      pst_pkg::CMD_RD_SIZE: wk_rd = rsize;
      pst_pkg::CMD_CHECK: begin
        if (rsize == 16'd0) wk_status = pst_pkg::ST_BAD_DEVICE;
      end
      pst_pkg::CMD_TRANSLATE: begin
        if ((sn_q == 16'd0) || (sn_q > rsize)) begin
          wk_status = pst_pkg::ST_BAD_SECTOR;
        end else begin
          wk_addr = acc_q + 22'(sn_q);
          wk_len  = (sn_q <= pst_pkg::SHORT_LAST) ? pst_pkg::SHORT_LEN : 9'(SECTOR_BYTES);
        end
      end
      default: wk_status = pst_pkg::ST_OK;
    endcase
  end

  // autopart fill
  assign rem       = {1'b0, cfg_i.drive_sectors} - 33'(sec_q);
  assign full      = !rem[32] && (rem[31:0] > 32'(pst_pkg::FULL_PART));
  assign auto_val  = full ? pst_pkg::FULL_PART : (rem[32] ? 16'd0 : rem[15:0]);
  assign auto_done = !full || (issue_q == CNT_W'(PARTITIONS - 1));

  assign mem_we    = (ctl_i.eval && ev_size_we) || ctl_i.auto_step;
  assign mem_waddr = ctl_i.auto_step ? issue_q[PART_AW-1:0] : idx_q[PART_AW-1:0];
  assign mem_wdata = ctl_i.auto_step ? auto_val : val_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) size_mem[mem_waddr] <= mem_wdata;
    if (rd_en)  rdata_q <= size_mem[issue_q[PART_AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_vld_q <= '0;
      rvbit_q    <= 1'b0;
      issue_q    <= '0;
      rd_vld_q   <= 1'b0;
      rd_idx_q   <= '0;
      target_q   <= '0;
      acc_q      <= '0;
      sec_q      <= '0;
    end else begin
      if (ctl_i.eval && ev_auto) size_vld_q <= '0;
      else if (mem_we)           size_vld_q[mem_waddr] <= 1'b1;
      if (rd_en) rvbit_q <= size_vld_q[issue_q[PART_AW-1:0]];

      if (ctl_i.eval) begin
        issue_q  <= CNT_W'(ev_start);
        rd_vld_q <= 1'b0;
        target_q <= ev_target;
        acc_q    <= '0;
        sec_q    <= 22'd1;
      end else if (ctl_i.walk_step) begin
        rd_vld_q <= rd_en;
        if (rd_en) begin
          rd_idx_q <= issue_q[PART_AW-1:0];
          issue_q  <= issue_q + 1'b1;
        end
        if (rd_vld_q && (rd_idx_q < target_q)) acc_q <= acc_q + 22'(rsize);
      end else if (ctl_i.auto_step) begin
        issue_q <= issue_q + 1'b1;
        if (full) sec_q <= sec_q + 22'(pst_pkg::FULL_PART);
      end
    end
  end

  // result staging and output register
  always_ff @(posedge clk_i) begin
    if (ctl_i.eval) begin
      res_status_q <= ev_status;
      res_addr_q   <= '0;
      res_len_q    <= '0;
      res_rd_q     <= ev_rd;
    end else if (ctl_i.walk_step && walk_done) begin
      res_status_q <= wk_status;
      res_addr_q   <= wk_addr;
      res_len_q    <= wk_len;
      res_rd_q     <= wk_rd;
    end
    if (ctl_i.out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
      out_len_q    <= res_len_q;
      out_rd_q     <= res_rd_q;
    end
  end

  always_comb begin
    stat_o            = '0;
    stat_o.early_done = ev_early;
    stat_o.is_auto    = ev_auto;
    stat_o.walk_done  = walk_done;
    stat_o.auto_done  = auto_done;
  end

  assign accepted_o       = (out_status_q == pst_pkg::ST_OK);
  assign status_o         = out_status_q;
  assign sector_address_o = out_addr_q;
  assign sector_length_o  = out_len_q;
  assign read_value_o     = out_rd_q;

endmodule
